>>> src/lcf_pkg.sv
// Shared types, constants and configuration codes of the mood-lamp color engine.
package lcf_pkg;

    // Default sizes handed to the top level.
    localparam int PALETTE_DEPTH_DEF = 16;
    localparam int MAX_LEDS_DEF      = 32;

    // Fixed field widths.
    localparam int COLOR_W   = 24;
    localparam int CHAN_W    = 8;
    localparam int DELAY_W   = 10;
    localparam int SLOT_W    = 4;
    localparam int PICK_W    = 16;
    localparam int JITTER_W  = 5;
    localparam int LEDIDX_W  = 5;
    localparam int MASK_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // Stream payload widths, padded to whole bytes.
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 40;

    // Shared divider: dividend and divisor widths.
    localparam int DIV_N_W   = 16;
    localparam int DIV_D_W   = 9;
    localparam int DIV_CNT_W = 4;

    // Numerator of the tick interval.
    localparam logic [DIV_N_W-1:0] DELAY_NUM = 16'd1000;

    // Input item kinds carried in tuser.
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LIQUID_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_SPEED    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_MASK      = 3'd4;

    // Request to the shared divider.
    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

    // Response of the shared divider.
    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
        logic [DIV_D_W-1:0] remainder;
    } div_rsp_t;

endpackage

>>> src/lcf_div.sv
// Shared restoring divider: one quotient bit per cycle, quotient and remainder out.
module lcf_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  lcf_pkg::div_req_t req,
    output lcf_pkg::div_rsp_t rsp
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [lcf_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [lcf_pkg::DIV_D_W-1:0]     rem_reg;
    logic [lcf_pkg::DIV_N_W-1:0]     quo_reg;
    logic [lcf_pkg::DIV_D_W-1:0]     dvs_reg;

    logic [lcf_pkg::DIV_D_W:0]       trial;
    logic [lcf_pkg::DIV_D_W:0]       diff;
    logic                            fits;
    logic [lcf_pkg::DIV_D_W-1:0]     rem_next;

    // One trial subtraction of the partial remainder.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[lcf_pkg::DIV_N_W-1]};
        fits     = trial >= {1'b0, dvs_reg};
        diff     = trial - {1'b0, dvs_reg};
        rem_next = fits ? diff[lcf_pkg::DIV_D_W-1:0] : trial[lcf_pkg::DIV_D_W-1:0];
    end

    // Iteration control; the quotient bits shift in where the dividend shifts out.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[lcf_pkg::DIV_N_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == lcf_pkg::DIV_CNT_W'(lcf_pkg::DIV_N_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

>>> src/led_color_fader_shuffle_palette_top.sv
// Top level of the mood-lamp color engine: sequencer, palette and bag memories, output stage.
//
// A palette write is taken while the sequencer stays idle. When the color is only
// stepped, a tick goes from idle through the step state to emitting. When a new
// target is drawn, the tick adds two passes of the shared 16-step divider
// (interval and bag index). When the bag is empty it also adds a refill that
// copies each palette entry in use, and every bag entry above the drawn one is
// read and written back one place lower. The sequencer then emits one LED result
// per cycle while the output is taken.
// The input is ready only while the sequencer is idle; the last result of a
// tick may still wait in the output register while the next item is accepted.
// Palette and bag contents are undefined until written; no clearing pass runs.
module led_color_fader_shuffle_palette_top
#(
    parameter int PALETTE_DEPTH = lcf_pkg::PALETTE_DEPTH_DEF,
    parameter int MAX_LEDS      = lcf_pkg::MAX_LEDS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration write port.
    input  logic                          cfg_we,
    input  logic [lcf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lcf_pkg::CFG_DAT_W-1:0] cfg_data,
    // Input requests.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tdata: entry_index[3:0], entry_color[27:4], pick_random[43:28],
    //        jitter_random[48:44], zero fill[55:49]
    input  logic [lcf_pkg::S_DATA_W-1:0]  s_tdata,
    // tuser: action[0]
    input  logic                          s_tuser,
    // Output requests.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tdata: led_index[4:0], led_color[28:5], delay_ms[38:29], zero fill[39]
    output logic [lcf_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tlast
);

    localparam int PIDX_W = $clog2(PALETTE_DEPTH);
    localparam int UW     = $clog2(PALETTE_DEPTH + 1);
    localparam int LCNT_W = $clog2(MAX_LEDS + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD0,
        ST_DLY_WAIT,
        ST_FILL,
        ST_MOD_WAIT,
        ST_BAG_GET,
        ST_SH_RD,
        ST_SH_WR,
        ST_STEP,
        ST_EMIT
    } state_t;

    // Step one channel toward its target.
    function automatic logic [lcf_pkg::CHAN_W-1:0] step_toward(
        input logic [lcf_pkg::CHAN_W-1:0] cur,
        input logic [lcf_pkg::CHAN_W-1:0] tgt
    );
        logic [lcf_pkg::CHAN_W-1:0] res;
        if (cur > tgt)
            res = cur - 1'b1;
        else if (cur < tgt)
            res = cur + 1'b1;
        else
            res = cur;
        return res;
    endfunction

    state_t                            state_reg;

    // Configuration registers.
    logic                              liquid_mode_reg;
    logic [7:0]                        fade_speed_reg;
    logic [4:0]                        palette_count_reg;
    logic [5:0]                        led_count_reg;
    logic [lcf_pkg::MASK_W-1:0]        led_mask_reg;

    // Lamp state.
    logic [UW-1:0]                     bag_size_reg;
    logic [lcf_pkg::CHAN_W-1:0]        cur_r_reg, cur_g_reg, cur_b_reg;
    logic [lcf_pkg::CHAN_W-1:0]        tgt_r_reg, tgt_g_reg, tgt_b_reg;
    logic [lcf_pkg::DELAY_W-1:0]       tick_delay_reg;

    // Sequencer working registers.
    logic [UW-1:0]                     k_reg;
    logic [lcf_pkg::PICK_W-1:0]        pick_reg;
    logic [lcf_pkg::COLOR_W-1:0]       rgb_reg;
    logic [LCNT_W-1:0]                 led_i_reg;
    lcf_pkg::div_req_t                 div_req_reg;
    lcf_pkg::div_rsp_t                 div_rsp;

    // Output stage.
    logic                              m_tvalid_reg;
    logic [lcf_pkg::M_DATA_W-1:0]      m_tdata_reg;
    logic                              m_tlast_reg;

    // Memories.
    logic [lcf_pkg::COLOR_W-1:0]       palette_mem [PALETTE_DEPTH];
    logic [lcf_pkg::COLOR_W-1:0]       bag_mem     [PALETTE_DEPTH];
    logic [lcf_pkg::COLOR_W-1:0]       pal_q_reg;
    logic [lcf_pkg::COLOR_W-1:0]       bag_q_reg;
    logic [PIDX_W-1:0]                 pal_raddr;
    logic [PIDX_W-1:0]                 bag_raddr;
    logic                              bag_we;
    logic [PIDX_W-1:0]                 bag_waddr;
    logic [lcf_pkg::COLOR_W-1:0]       bag_wdata;
    logic                              pal_we;

    // Input fields.
    logic [lcf_pkg::SLOT_W-1:0]        entry_index;
    logic [lcf_pkg::COLOR_W-1:0]       entry_color;
    logic [lcf_pkg::PICK_W-1:0]        pick_random;
    logic [lcf_pkg::JITTER_W-1:0]      jitter_random;
    logic                              accept;

    // Derived values.
    logic [UW-1:0]                     used;
    logic [LCNT_W-1:0]                 leds;
    logic                              at_target;
    logic [lcf_pkg::CHAN_W-1:0]        cur_r_next, cur_g_next, cur_b_next;
    logic [7:0]                        led_wide;
    logic                              led_on;
    logic                              out_free;
    logic [UW-1:0]                     k_plus1;

    assign entry_index   = s_tdata[3:0];
    assign entry_color   = s_tdata[27:4];
    assign pick_random   = s_tdata[43:28];
    assign jitter_random = s_tdata[48:44];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign pal_we   = accept && (s_tuser == lcf_pkg::ACT_WRITE)
                      && (32'(entry_index) < PALETTE_DEPTH);

    // Saturated counts and the fade step.
    always_comb
    begin
        used = (32'(palette_count_reg) > PALETTE_DEPTH) ? UW'(PALETTE_DEPTH)
                                                         : UW'(palette_count_reg);
        leds = (32'(led_count_reg) > MAX_LEDS) ? LCNT_W'(MAX_LEDS)
                                                : LCNT_W'(led_count_reg);
        at_target  = (cur_r_reg == tgt_r_reg) && (cur_g_reg == tgt_g_reg)
                     && (cur_b_reg == tgt_b_reg);
        cur_r_next = step_toward(cur_r_reg, tgt_r_reg);
        cur_g_next = step_toward(cur_g_reg, tgt_g_reg);
        cur_b_next = step_toward(cur_b_reg, tgt_b_reg);
        led_wide   = 8'(led_i_reg);
        led_on     = (led_wide < 8'd32) && led_mask_reg[led_wide[4:0]];
        out_free   = !m_tvalid_reg || m_tready;
        k_plus1    = k_reg + UW'(1);
    end

    // Memory addresses and bag writes.
    always_comb
    begin
        pal_raddr = '0;
        bag_raddr = '0;
        bag_we    = 1'b0;
        bag_waddr = '0;
        bag_wdata = pal_q_reg;
        unique case (state_reg)
            ST_FILL:
            begin
                pal_raddr = PIDX_W'(k_reg);
                bag_we    = (k_reg != '0);
                bag_waddr = PIDX_W'(k_reg - UW'(1));
                bag_wdata = pal_q_reg;
            end
            ST_MOD_WAIT:
            begin
                bag_raddr = PIDX_W'(div_rsp.remainder);
            end
            ST_SH_RD:
            begin
                bag_raddr = PIDX_W'(k_plus1);
            end
            ST_SH_WR:
            begin
                bag_we    = 1'b1;
                bag_waddr = PIDX_W'(k_reg);
                bag_wdata = bag_q_reg;
            end
            default:
            begin
                pal_raddr = '0;
            end
        endcase
    end

    // Palette memory with registered read.
    always_ff @(posedge clk)
    begin
        if (pal_we)
            palette_mem[PIDX_W'(entry_index)] <= entry_color;
        pal_q_reg <= palette_mem[pal_raddr];
    end

    // Shuffle bag memory with registered read.
    always_ff @(posedge clk)
    begin
        if (bag_we)
            bag_mem[bag_waddr] <= bag_wdata;
        bag_q_reg <= bag_mem[bag_raddr];
    end

    // Shared divider for the tick interval and the bag index.
    lcf_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .rsp   (div_rsp)
    );

    // Sequencer, configuration registers and output stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            liquid_mode_reg   <= 1'b0;
            fade_speed_reg    <= '0;
            palette_count_reg <= '0;
            led_count_reg     <= '0;
            led_mask_reg      <= '1;
            bag_size_reg      <= '0;
            cur_r_reg         <= '0;
            cur_g_reg         <= '0;
            cur_b_reg         <= '0;
            tgt_r_reg         <= '0;
            tgt_g_reg         <= '0;
            tgt_b_reg         <= '0;
            tick_delay_reg    <= '0;
            k_reg             <= '0;
            pick_reg          <= '0;
            rgb_reg           <= '0;
            led_i_reg         <= '0;
            div_req_reg       <= '0;
            m_tvalid_reg      <= 1'b0;
            m_tdata_reg       <= '0;
            m_tlast_reg       <= 1'b0;
        end
        else
        begin
            div_req_reg.start <= 1'b0;
            if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;

            // Configuration writes.
            if (cfg_we)
            begin
                unique case (cfg_index)
                    lcf_pkg::CFG_LIQUID_MODE:   liquid_mode_reg   <= cfg_data[0];
                    lcf_pkg::CFG_FADE_SPEED:    fade_speed_reg    <= cfg_data[7:0];
                    lcf_pkg::CFG_PALETTE_COUNT: palette_count_reg <= cfg_data[4:0];
                    lcf_pkg::CFG_LED_COUNT:     led_count_reg     <= cfg_data[5:0];
                    lcf_pkg::CFG_LED_MASK:      led_mask_reg      <= cfg_data;
                    default:                    ;
                endcase
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (s_tuser == lcf_pkg::ACT_TICK))
                    begin
                        pick_reg  <= pick_random;
                        led_i_reg <= '0;
                        if (liquid_mode_reg && (used > UW'(1)))
                        begin
                            if (at_target)
                            begin
                                div_req_reg.start    <= 1'b1;
                                div_req_reg.dividend <= lcf_pkg::DELAY_NUM;
                                div_req_reg.divisor  <=
                                    lcf_pkg::DIV_D_W'(fade_speed_reg)
                                    + lcf_pkg::DIV_D_W'(jitter_random)
                                    + lcf_pkg::DIV_D_W'(1);
                                state_reg <= ST_DLY_WAIT;
                            end
                            else
                            begin
                                state_reg <= ST_STEP;
                            end
                        end
                        else if (used != '0)
                        begin
                            state_reg <= ST_LOAD0;
                        end
                        else
                        begin
                            rgb_reg   <= '0;
                            state_reg <= ST_EMIT;
                        end
                    end
                end

                // Static color: palette entry 0 was read at the accept edge.
                ST_LOAD0:
                begin
                    rgb_reg   <= pal_q_reg;
                    state_reg <= ST_EMIT;
                end

                // New interval ready; refill the bag if it ran empty.
                ST_DLY_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        tick_delay_reg <= div_rsp.quotient[lcf_pkg::DELAY_W-1:0];
                        if (bag_size_reg == '0)
                        begin
                            k_reg     <= '0;
                            state_reg <= ST_FILL;
                        end
                        else
                        begin
                            div_req_reg.start    <= 1'b1;
                            div_req_reg.dividend <= pick_reg;
                            div_req_reg.divisor  <= lcf_pkg::DIV_D_W'(bag_size_reg);
                            state_reg            <= ST_MOD_WAIT;
                        end
                    end
                end

                // Copy the palette into the bag, one entry behind the read.
                ST_FILL:
                begin
                    if (k_reg == used)
                    begin
                        bag_size_reg         <= used;
                        div_req_reg.start    <= 1'b1;
                        div_req_reg.dividend <= pick_reg;
                        div_req_reg.divisor  <= lcf_pkg::DIV_D_W'(used);
                        state_reg            <= ST_MOD_WAIT;
                    end
                    else
                    begin
                        k_reg <= k_plus1;
                    end
                end

                // Bag index ready; its entry is read in this cycle.
                ST_MOD_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        k_reg     <= UW'(div_rsp.remainder);
                        state_reg <= ST_BAG_GET;
                    end
                end

                ST_BAG_GET:
                begin
                    tgt_r_reg <= bag_q_reg[23:16];
                    tgt_g_reg <= bag_q_reg[15:8];
                    tgt_b_reg <= bag_q_reg[7:0];
                    state_reg <= ST_SH_RD;
                end

                // Close the gap left by the drawn entry.
                ST_SH_RD:
                begin
                    if (k_plus1 < bag_size_reg)
                    begin
                        state_reg <= ST_SH_WR;
                    end
                    else
                    begin
                        bag_size_reg <= bag_size_reg - UW'(1);
                        state_reg    <= ST_STEP;
                    end
                end

                ST_SH_WR:
                begin
                    k_reg     <= k_plus1;
                    state_reg <= ST_SH_RD;
                end

                ST_STEP:
                begin
                    cur_r_reg <= cur_r_next;
                    cur_g_reg <= cur_g_next;
                    cur_b_reg <= cur_b_next;
                    rgb_reg   <= {cur_r_next, cur_g_next, cur_b_next};
                    state_reg <= ST_EMIT;
                end

                // One LED result per free output slot.
                ST_EMIT:
                begin
                    if (led_i_reg == leds)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {1'b0, tick_delay_reg,
                                         led_on ? rgb_reg : {lcf_pkg::COLOR_W{1'b0}},
                                         led_wide[lcf_pkg::LEDIDX_W-1:0]};
                        m_tlast_reg  <= ((led_i_reg + LCNT_W'(1)) == leds);
                        led_i_reg    <= led_i_reg + LCNT_W'(1);
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
